>>> src/modular_exponentiation_defines.svh
// Assertion macros used by the modular exponentiation controller
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define MEXP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("mexp check failed");

// Next-cycle implication, disabled while in reset
`define MEXP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("mexp check failed");

`endif

>>> src/mexp_pkg.sv
// Package: types, constants and the modular step function for modular exponentiation
`default_nettype none
package mexp_pkg;
	localparam int MOD_W        = 31;
	localparam int BASE_W       = 64;
	localparam int EXP_BITS_DEF = 63;
	localparam int RED_CNT_W    = $clog2(BASE_W);
	localparam int MUL_CNT_W    = $clog2(MOD_W);
	localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REDUCE,
		S_FIX,
		S_CHECK,
		S_MUL,
		S_UPDATE,
		S_DONE
	} mexp_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic red_step;
		logic fix;
		logic mul_init;
		logic mul_step;
		logic exp_step;
		logic finish;
	} mexp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic red_last;
		logic mul_last;
		logic e_done;
	} mexp_sts_t;

	// one step of interleaved modular multiply: r = (2r + bit*a) mod m, r,a < m
	function automatic logic [MOD_W-1:0] mod_step(input logic [MOD_W-1:0] r,
			input logic [MOD_W-1:0] a, input logic mbit, input logic [MOD_W-1:0] m);
		logic [MOD_W:0] t;
		logic [MOD_W:0] u;
		t = {r, 1'b0};
		if (t >= {1'b0, m}) begin
			t = t - {1'b0, m};
		end
		u = t;
		if (mbit) begin
			u = t + {1'b0, a};
			if (u >= {1'b0, m}) begin
				u = u - {1'b0, m};
			end
		end
		return u[MOD_W-1:0];
	endfunction
endpackage
`default_nettype wire

>>> src/mexp_ctrl.sv
// Controller state machine: sequences reduction, multiply passes and result hand-off
`default_nettype none
`include "modular_exponentiation_defines.svh"
module mexp_ctrl
	import mexp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire logic      rsp_free,
	input  wire mexp_sts_t sts,
	output mexp_cmd_t      cmd
);
	mexp_state_t state_q;
	mexp_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_REDUCE;
			end
			S_REDUCE: begin
				if (sts.red_last) state_d = S_FIX;
			end
			S_FIX:    state_d = S_CHECK;
			S_CHECK: begin
				state_d = sts.e_done ? S_DONE : S_MUL;
			end
			S_MUL: begin
				if (sts.mul_last) state_d = S_UPDATE;
			end
			S_UPDATE: state_d = S_CHECK;
			S_DONE: begin
				if (rsp_free) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			S_REDUCE: cmd.red_step = 1'b1;
			S_FIX:    cmd.fix      = 1'b1;
			S_CHECK:  cmd.mul_init = !sts.e_done;
			S_MUL:    cmd.mul_step = 1'b1;
			S_UPDATE: cmd.exp_step = 1'b1;
			S_DONE:   cmd.finish   = rsp_free;
			default:  cmd          = '0;
		endcase
	end

	`MEXP_ASSERT_NEXT(a_accept_reduce, clk, arst_n, req_valid && req_ready, state_q == S_REDUCE)
	`MEXP_ASSERT_NOW(a_finish_free, clk, arst_n, cmd.finish, rsp_free)
	`MEXP_ASSERT_NEXT(a_mul_update, clk, arst_n, state_q == S_MUL && sts.mul_last,
		state_q == S_UPDATE)
endmodule
`default_nettype wire

>>> src/mexp_dp.sv
// Datapath: bit-serial base reduction, exponent shifter, two-lane interleaved modular multiply
`default_nettype none
module mexp_dp
	import mexp_pkg::*;
#(
	parameter int EXP_BITS = EXP_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic [MOD_W-1:0]    modulus,
	input  wire logic                op,
	input  wire logic [BASE_W-1:0]   base,
	input  wire logic [EXP_BITS-1:0] exponent,
	input  wire mexp_cmd_t           cmd,
	output mexp_sts_t                sts,
	output logic [MOD_W-1:0]         result
);
	localparam int EW = (EXP_BITS > MOD_W) ? EXP_BITS : MOD_W;

	logic [MOD_W-1:0]     m_q;
	logic                 neg_q;
	logic [BASE_W-1:0]    mag_q;
	logic [MOD_W-1:0]     red_q;
	logic [RED_CNT_W-1:0] cnt_q;
	logic [EW-1:0]        e_q;
	logic [MOD_W-1:0]     acc_q;
	logic [MOD_W-1:0]     b_q;
	logic [MOD_W-1:0]     ra_q;
	logic [MOD_W-1:0]     rb_q;
	logic [MUL_CNT_W-1:0] mc_q;

	logic [MOD_W:0]       red_t;
	logic [MOD_W:0]       red_n;
	logic [EW-1:0]        e_load;

	always_comb begin
		red_t = {red_q, mag_q[BASE_W-1]};
		red_n = (red_t >= {1'b0, m_q}) ? red_t - {1'b0, m_q} : red_t;
	end

	always_comb begin
		if (op) begin
			e_load = (modulus >= MOD_W'(2)) ? EW'(modulus - MOD_W'(2)) : '0;
		end else begin
			e_load = EW'(exponent);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q   <= modulus;
			neg_q <= base[BASE_W-1];
			mag_q <= base[BASE_W-1] ? (~base + BASE_W'(1)) : base;
			red_q <= '0;
			cnt_q <= '0;
			e_q   <= e_load;
		end
		if (cmd.red_step) begin
			red_q <= red_n[MOD_W-1:0];
			mag_q <= {mag_q[BASE_W-2:0], 1'b0};
			cnt_q <= cnt_q + RED_CNT_W'(1);
		end
		if (cmd.fix) begin
			// negative base: move a non-zero remainder up into range
			b_q   <= (neg_q && red_q != '0) ? m_q - red_q : red_q;
			acc_q <= MOD_W'(1);
		end
		if (cmd.mul_init) begin
			ra_q <= '0;
			rb_q <= '0;
			mc_q <= MUL_CNT_W'(MOD_W - 1);
		end
		if (cmd.mul_step) begin
			// lane a: acc * b, lane b: b * b, multiplier bits of b from the top
			ra_q <= mod_step(ra_q, acc_q, b_q[mc_q], m_q);
			rb_q <= mod_step(rb_q, b_q, b_q[mc_q], m_q);
			mc_q <= mc_q - MUL_CNT_W'(1);
		end
		if (cmd.exp_step) begin
			if (e_q[0]) acc_q <= ra_q;
			b_q <= rb_q;
			e_q <= e_q >> 1;
		end
	end

	assign sts.red_last = (cnt_q == RED_CNT_W'(BASE_W - 1));
	assign sts.mul_last = (mc_q == '0);
	assign sts.e_done   = (e_q == '0) || (m_q == '0);
	assign result       = (m_q == '0) ? '0 : acc_q;
endmodule
`default_nettype wire

>>> src/modular_exponentiation.sv
// Requests are processed one at a time: a bit-serial base reduction, then one interleaved
// multiply pass per bit of the exponent used; a new request is not taken until the
// previous one has finished.
// A new request is taken while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous) returns to idle, drops any pending result and
// sets the modulus to 1000000007.
`default_nettype none
module modular_exponentiation
	import mexp_pkg::*;
#(
	parameter int EXP_BITS = EXP_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// modulus register write
	input  wire logic                modulus_we,
	input  wire logic [MOD_W-1:0]    modulus_wdata,
	// request channel
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire logic                op,
	input  wire logic [BASE_W-1:0]   base,
	input  wire logic [EXP_BITS-1:0] exponent,
	// result channel
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output logic [MOD_W-1:0]         value
);
	logic [MOD_W-1:0] modulus_q;
	logic             rsp_valid_q;
	logic [MOD_W-1:0] value_q;
	logic             rsp_free;
	logic [MOD_W-1:0] result;
	mexp_cmd_t        cmd;
	mexp_sts_t        sts;

	// modulus register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
		end else if (modulus_we) begin
			modulus_q <= modulus_wdata;
		end
	end

	// output register: holds one finished result until taken
	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) value_q <= result;
	end

	assign rsp_valid = rsp_valid_q;
	assign value     = value_q;

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_free  (rsp_free),
		.sts       (sts),
		.cmd       (cmd)
	);

	mexp_dp #(
		.EXP_BITS (EXP_BITS)
	) u_dp (
		.clk      (clk),
		.modulus  (modulus_q),
		.op       (op),
		.base     (base),
		.exponent (exponent),
		.cmd      (cmd),
		.sts      (sts),
		.result   (result)
	);
endmodule
`default_nettype wire

>>> bench/tb_modular_exponentiation.sv
// Self-checking testbench for the modular exponentiation block
`default_nettype none
module tb_modular_exponentiation;
	import mexp_pkg::*;

	// Scoreboard: predicts each request's value and checks results in order
	class powmod_board;
		logic [MOD_W-1:0] modulus;
		logic [MOD_W-1:0] pending[$];
		int errors;

		function new();
			modulus = MODULUS_RESET;
			errors = 0;
		endfunction

		// interleaved multiply, one bit at a time, to keep products within 64 bits
		function logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
			logic [63:0] r;
			r = 0;
			for (int i = 30; i >= 0; i--) begin
				r = (r << 1) % m;
				if (b[i]) r = (r + a) % m;
			end
			return r;
		endfunction

		function logic [MOD_W-1:0] powmod(logic o, logic [63:0] b, logic [62:0] e);
			logic [63:0] m, ex, acc, x, mag;
			m = {33'd0, modulus};
			if (o) ex = (m >= 2) ? m - 2 : 0;
			else ex = {1'b0, e};
			if (m == 0) return 0;
			if (ex == 0) return 1;
			mag = b[63] ? -b : b;
			x = mag % m;
			if (b[63] && x != 0) x = m - x;
			acc = 1;
			while (ex != 0) begin
				if (ex[0]) acc = mulmod(acc, x, m);
				x = mulmod(x, x, m);
				ex = ex >> 1;
			end
			return acc[MOD_W-1:0];
		endfunction

		function void note_request(logic o, logic [63:0] b, logic [62:0] e);
			pending = {pending, powmod(o, b, e)};
		endfunction

		function void check_result(logic [MOD_W-1:0] got);
			logic [MOD_W-1:0] want;
			if (pending.size() == 0) begin
				$error("value: unexpected result %0d", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$error("value: expected %0d, got %0d", want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic modulus_we = 0;
	logic [MOD_W-1:0] modulus_wdata = 0;
	logic req_valid = 0;
	logic req_ready;
	logic op = 0;
	logic [BASE_W-1:0] base = 0;
	logic [62:0] exponent = 0;
	logic rsp_valid;
	logic rsp_ready = 0;
	logic [MOD_W-1:0] value;

	powmod_board board = new();
	int send_idle = 0;    // percent of cycles the sender idles
	int recv_idle = 0;    // percent of cycles the receiver stalls
	bit hold_off = 0;     // long receiver stall
	bit timed_out = 0;
	longint cycles = 0;

	always #4 clk = ~clk;

	modular_exponentiation u_dut (
		.clk(clk), .arst_n(arst_n),
		.modulus_we(modulus_we), .modulus_wdata(modulus_wdata),
		.req_valid(req_valid), .req_ready(req_ready),
		.op(op), .base(base), .exponent(exponent),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .value(value)
	);

	// Result side: sample at the rising edge, choose ready at the falling edge
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) board.check_result(value);
	end

	always @(negedge clk) begin
		rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
	end

	// Cycle limit: sets timed_out once the cycle count passes a generous bound
	always @(posedge clk) begin
		cycles++;
		if (cycles > 64'd30_000_000) timed_out = 1;
	end

	// Offer one request and hold it until accepted; valid stays up for a
	// directly following request and drops when the sender idles, for a modulus change or at the end
	task automatic send_request(logic o, logic [63:0] b, logic [62:0] e);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 0;
			@(negedge clk);
		end
		op <= o;
		base <= b;
		exponent <= e;
		req_valid <= 1;
		do @(posedge clk); while (!req_ready);
		board.note_request(o, b, e);
		@(negedge clk);
	endtask

	// Modulus change only when the block is idle
	task automatic set_modulus(logic [MOD_W-1:0] m);
		req_valid <= 0;
		@(negedge clk);
		while (board.pending.size() != 0) @(negedge clk);
		repeat (2200) @(negedge clk);
		modulus_we <= 1;
		modulus_wdata <= m;
		@(negedge clk);
		modulus_we <= 0;
		board.modulus = m;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly short exponents to keep run time down, some full width
	function automatic logic [62:0] rand_exp();
		logic [63:0] r;
		r = rand64();
		case ($urandom_range(9))
			0: return r[62:0];
			1, 2: return 63'(r[15:0]);
			default: return 63'(r[7:0]);
		endcase
	endfunction

	task automatic random_phase(int n);
		logic [63:0] b;
		for (int i = 0; i < n; i++) begin
			b = rand64();
			if ($urandom_range(3) == 0) b = 64'($signed(b[15:0]));
			send_request($urandom_range(3) == 0, b, rand_exp());
		end
	endtask

	// Long receiver stall while requests keep coming
	initial begin
		wait (arst_n);
		repeat (300) @(negedge clk);
		hold_off = 1;
		repeat (5000) @(negedge clk);
		hold_off = 0;
	end

	initial begin
		logic [MOD_W-1:0] mods[6];
		mods = '{31'd2147483647, 31'd1, 31'd2, 31'd3, 31'd65521, 31'd1000000};
		repeat (2) @(negedge clk);
		arst_n = 1;
		send_idle = 10; recv_idle = 61;

		// directed: extremes of base and exponent, both ops, reset modulus
		send_request(0, 64'h8000_0000_0000_0000, 63'h7FFF_FFFF_FFFF_FFFF);
		send_request(0, 64'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
		send_request(0, 64'hFFFF_FFFF_FFFF_FFFF, 63'd3);
		send_request(0, 64'd12345, 63'd0);
		send_request(0, 64'd0, 63'd5);
		send_request(1, 64'd2, 63'd0);
		send_request(1, -64'sd2, 63'h7FFF_FFFF_FFFF_FFFF);
		send_request(1, 64'd1000000007, 63'd9);  // multiple of the modulus
		send_request(1, 64'h8000_0000_0000_0000, 63'd0);
		send_request(0, -64'sd1000000007, 63'd1);

		random_phase(300);

		foreach (mods[k]) begin
			set_modulus(mods[k]);
			// zero exponent with modulus one, inverse below two, etc.
			send_request(0, rand64(), 63'd0);
			send_request(1, rand64(), rand_exp());
			send_request(0, rand64(), 63'h7FFF_FFFF_FFFF_FFFF);
			send_request(1, 64'(mods[k]) * 3, 63'd1);
			case (k)
				2: begin send_idle = 61; recv_idle = 10; end
				4: begin send_idle = 0; recv_idle = 0; end
				default: ;
			endcase
			random_phase(200);
		end
		req_valid <= 0;
	end

	// End of run: wait for the last request, drain, then report
	initial begin
		wait (arst_n);
		fork
			begin
				wait (send_idle == 0 && recv_idle == 0);
				wait (board.modulus == 31'd1000000 && !hold_off);
				@(negedge clk);
				// keep waiting until stimulus has quiesced and results drained
				forever begin
					@(negedge clk);
					if (!req_valid && board.pending.size() == 0) begin
						repeat (2300) @(negedge clk);
						if (!req_valid && board.pending.size() == 0) break;
					end
				end
			end
			wait (timed_out);
		join_any
		if (timed_out) begin
			$display("[FAIL] regression broken");
		end else if (board.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> files.f
+incdir+src
src/mexp_pkg.sv
src/mexp_ctrl.sv
src/mexp_dp.sv
src/modular_exponentiation.sv
bench/tb_modular_exponentiation.sv
